// ----- src/mbrc_pkg.sv -----
// Shared types, constants and the CRC16 byte update for the response checker.
`default_nettype none

package mbrc_pkg;

   // Frame length handling
   localparam int MAX_FRAME_BYTES = 256;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 2);
   localparam logic [POS_W-1:0] POS_LIMIT     = POS_W'(MAX_FRAME_BYTES + 1);
   localparam logic [POS_W-1:0] MIN_FRAME_LEN = POS_W'(3);
   localparam logic [POS_W-1:0] EXC_FRAME_LEN = POS_W'(5);
   localparam logic [POS_W-1:0] FIRST_WORD_POS = POS_W'(3);
   localparam logic [POS_W-1:0] WORD_POS_BASE  = POS_W'(4);

   // Modbus CRC16
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Fixed field widths
   localparam int BYTE_W   = 8;
   localparam int IDX_W    = 7;
   localparam int WORD_W   = 16;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_DATA_W = 40;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EXCEPTION = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CRC       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LENGTH    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SLAVE     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FUNCTION  = 3'd6;
   localparam logic [STATUS_W-1:0] ST_BYTECOUNT = 3'd7;

   // Result kinds
   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SLAVE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FUNCTION  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REGISTERS = 2'd2;

   // Configuration reset values
   localparam logic [BYTE_W-1:0] RST_SLAVE     = 8'd1;
   localparam logic [BYTE_W-1:0] RST_FUNCTION  = 8'd3;
   localparam logic [IDX_W-1:0]  RST_REGISTERS = 7'd1;

   // One received byte
   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              last_byte;
   } in_item_type;

   // Input stage toward the frame logic
   typedef struct packed {
      logic        valid;
      in_item_type item;
   } in_stage_type;

   // One result item
   typedef struct packed {
      logic                kind;
      logic [IDX_W-1:0]    reg_index;
      logic [WORD_W-1:0]   reg_value;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   exc_code;
   } rsp_item_type;

   // Frame logic result for the current step
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_stage_type;

   // Byte-wide reflected CRC16 update, one bit per unrolled step
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [BYTE_W-1:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- src/mbrc_in_stage.sv -----
// Input register: holds one received byte until the frame logic takes it.
`default_nettype none

module mbrc_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire mbrc_pkg::in_item_type req_item,
   input  wire logic                  step,
   output mbrc_pkg::in_stage_type     stage
);
   import mbrc_pkg::*;

   logic        valid_ff, valid_in;
   in_item_type item_ff, item_in;

   // Free when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || step;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

// ----- src/mbrc_frame.sv -----
// Frame tracking: CRC, header capture, word assembly, status decode, config regs.
`default_nettype none

module mbrc_frame (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire mbrc_pkg::in_item_type   item,
   input  wire logic                    csr_valid,
   input  wire logic [mbrc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mbrc_pkg::BYTE_W-1:0]    csr_data,
   output mbrc_pkg::rsp_stage_type      result
);
   import mbrc_pkg::*;

   // Configuration
   logic [BYTE_W-1:0] exp_slave_ff;
   logic [BYTE_W-1:0] exp_function_ff;
   logic [IDX_W-1:0]  exp_registers_ff;

   // Frame state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [15:0]       crc_ff, crc_in;
   logic [BYTE_W-1:0] slave_ff, slave_in;
   logic [BYTE_W-1:0] function_ff, function_in;
   logic [BYTE_W-1:0] third_ff, third_in;
   logic [BYTE_W-1:0] pending_ff, pending_in;

   // Per-step values
   logic [POS_W-1:0]  len;
   logic [POS_W-1:0]  exp_len;
   logic [POS_W-1:0]  word_off;
   logic [IDX_W-1:0]  idx;
   logic [15:0]       crc_new;
   logic              in_body;
   logic              word_done;
   logic [STATUS_W-1:0] status;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_slave_ff     <= RST_SLAVE;
         exp_function_ff  <= RST_FUNCTION;
         exp_registers_ff <= RST_REGISTERS;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SLAVE:     exp_slave_ff     <= csr_data;
            REG_FUNCTION:  exp_function_ff  <= csr_data;
            REG_REGISTERS: exp_registers_ff <= csr_data[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   // Byte decode and header capture
   always_comb begin
      len      = (pos_ff < POS_LIMIT) ? pos_ff + POS_W'(1) : POS_LIMIT;
      crc_new  = crc_byte(crc_ff, item.frame_byte);
      exp_len  = EXC_FRAME_LEN + {{(POS_W-IDX_W-1){1'b0}}, exp_registers_ff, 1'b0};
      word_off = pos_ff - WORD_POS_BASE;
      idx      = IDX_W'(word_off >> 1);
      in_body  = (pos_ff >= FIRST_WORD_POS) && (pos_ff < POS_LIMIT);
      // Word completes on the second byte of each pair
      word_done = in_body && !pos_ff[0];

      slave_in    = (pos_ff == POS_W'(0)) ? item.frame_byte : slave_ff;
      function_in = (pos_ff == POS_W'(1)) ? item.frame_byte : function_ff;
      third_in    = (pos_ff == POS_W'(2)) ? item.frame_byte : third_ff;
      pending_in  = (in_body && pos_ff[0]) ? item.frame_byte : pending_ff;
      crc_in      = crc_new;
      pos_in      = len;

      // Status in priority order
      if (len < MIN_FRAME_LEN) begin
         status = ST_SHORT;
      end else if (len >= EXC_FRAME_LEN && function_in[7] && third_in != '0) begin
         status = ST_EXCEPTION;
      end else if (crc_new != '0) begin
         status = ST_CRC;
      end else if (len != exp_len) begin
         status = ST_LENGTH;
      end else if (slave_in != exp_slave_ff) begin
         status = ST_SLAVE;
      end else if (function_in != exp_function_ff) begin
         status = ST_FUNCTION;
      end else if (third_in != {exp_registers_ff, 1'b0}) begin
         status = ST_BYTECOUNT;
      end else begin
         status = ST_OK;
      end

      // Result for this byte
      result.valid          = 1'b0;
      result.item.kind      = KIND_WORD;
      result.item.reg_index = '0;
      result.item.reg_value = '0;
      result.item.status    = ST_OK;
      result.item.exc_code  = '0;
      if (item.last_byte) begin
         result.valid          = 1'b1;
         result.item.kind      = KIND_STATUS;
         result.item.status    = status;
         result.item.exc_code  = (status == ST_EXCEPTION) ? third_in : '0;
         // Frame ends: back to the idle frame state
         pos_in      = '0;
         crc_in      = CRC_INIT;
         slave_in    = '0;
         function_in = '0;
         third_in    = '0;
         pending_in  = '0;
      end else if (word_done && idx < exp_registers_ff) begin
         result.valid          = 1'b1;
         result.item.reg_index = idx;
         result.item.reg_value = {pending_ff, item.frame_byte};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         crc_ff      <= CRC_INIT;
         slave_ff    <= '0;
         function_ff <= '0;
         third_ff    <= '0;
         pending_ff  <= '0;
      end else if (step) begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         slave_ff    <= slave_in;
         function_ff <= function_in;
         third_ff    <= third_in;
         pending_ff  <= pending_in;
      end
   end

   // Position never runs past the saturation point
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("byte position beyond saturation");

   // A final byte leaves a fresh frame behind
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      step && item.last_byte |=> pos_ff == '0 && crc_ff == CRC_INIT)
      else $error("frame state not cleared after final byte");

   // Emitted word indexes stay inside the expected register count
   a_word_idx: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.item.kind == KIND_WORD |->
         result.item.reg_index < exp_registers_ff)
      else $error("word index beyond expected registers");

   // Only a status result carries an exception code
   a_exc_code: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.item.exc_code != '0 |->
         result.item.kind == KIND_STATUS && result.item.status == ST_EXCEPTION)
      else $error("exception code on a non-exception result");

endmodule

`default_nettype wire

// ----- src/mbrc_out_stage.sv -----
// Output register: holds one result item until the consumer takes it.
`default_nettype none

module mbrc_out_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire mbrc_pkg::rsp_stage_type result,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output mbrc_pkg::rsp_item_type       rsp_item
);
   import mbrc_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   // Load on each step (steps only happen when this stage is free or being emptied)
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (step) begin
         valid_in = result.valid;
         item_in  = result.item;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

`default_nettype wire

// ----- src/modbus_rtu_response_checker_top.sv -----
// Each byte waits in the input register; its result item is then loaded into the
// output register, which offers it on rsp_tvalid and holds it until it is taken.
// Throughput: one byte per cycle while results drain; a stalled result register
// holds the input register, and req_tready drops in that same cycle.
// Reset (synchronous, active high) empties both stages, clears the frame state
// and loads expected slave 1, function 3, registers 1.
`default_nettype none

module modbus_rtu_response_checker_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  wire logic        req_tlast,   // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [6:0] reg_index, [22:7] reg_value,
                                         // [25:23] status, [33:26] exc_code
   output logic             rsp_tuser,   // kind
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   import mbrc_pkg::*;

   in_item_type   req_item;
   in_stage_type  in_stage;
   rsp_stage_type result;
   rsp_item_type  rsp_item;
   logic          step;
   logic          rsp_busy;

   assign req_item.frame_byte = req_tdata;
   assign req_item.last_byte  = req_tlast;

   // Held byte advances when the output register is free or being emptied
   assign step = in_stage.valid && (!rsp_busy || rsp_tready);

   // Registers accept writes at any time
   assign csr_ready = 1'b1;

   mbrc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .step       (step),
      .stage      (in_stage)
   );

   mbrc_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_stage.item),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .result    (result)
   );

   mbrc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .result     (result),
      .rsp_tvalid (rsp_busy),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tvalid = rsp_busy;
   assign rsp_tuser  = rsp_item.kind;
   assign rsp_tdata  = {6'b0, rsp_item.exc_code, rsp_item.status,
                        rsp_item.reg_value, rsp_item.reg_index};

endmodule

`default_nettype wire
